@@ rtl/rvcd_pkg.sv @@
// ----------------------------------------------------------------------------
// rvcd_pkg
// Shared types and constants for the window count / distinct count block.
// ----------------------------------------------------------------------------
package rvcd_pkg;

   localparam int ARRAY_DEPTH = 1024;
   localparam int VALUE_RANGE = 1024;
   localparam int IDX_W       = $clog2(ARRAY_DEPTH);
   localparam int VAL_W       = $clog2(VALUE_RANGE);
   localparam int CNT_W       = 11;
   localparam int EPOCH_W     = 8;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 24;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic query_start;
      logic walk_step;
      logic clear_step;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic window_empty;
      logic walk_last;
      logic pipe_busy;
      logic clear_last;
      logic epoch_last;
   } status_type;

endpackage

@@ rtl/rvcd_datapath.sv @@
// ----------------------------------------------------------------------------
// rvcd_datapath
// Element store, epoch-tagged seen marks, two-stage walk pipeline, counters
// and result register.
// ----------------------------------------------------------------------------
module rvcd_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  rvcd_pkg::cmd_type                  cmd,
   output rvcd_pkg::status_type               status,
   input  logic [rvcd_pkg::IDX_W-1:0]         elem_index,
   input  logic [rvcd_pkg::VAL_W-1:0]         elem_value,
   input  logic [rvcd_pkg::IDX_W-1:0]         left_index,
   input  logic [rvcd_pkg::IDX_W-1:0]         right_index,
   input  logic [rvcd_pkg::VAL_W-1:0]         value_min,
   input  logic [rvcd_pkg::VAL_W-1:0]         value_max,
   output logic [rvcd_pkg::CNT_W-1:0]         match_count,
   output logic [rvcd_pkg::CNT_W-1:0]         distinct_count
);
   import rvcd_pkg::*;

   logic [VAL_W-1:0]   elem_mem [ARRAY_DEPTH];
   logic [EPOCH_W-1:0] seen_mem [VALUE_RANGE];

   logic [VAL_W-1:0]   elem_rd_ff;
   logic [EPOCH_W-1:0] seen_rd_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [VAL_W-1:0]   vmin_ff, vmin_in;
   logic [VAL_W-1:0]   vmax_ff, vmax_in;
   logic [VAL_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_match_ff, s2_match_in;
   logic [VAL_W-1:0]   s2_value_ff;
   logic               wr_en_ff, wr_en_in;
   logic [VAL_W-1:0]   wr_val_ff;
   logic [CNT_W-1:0]   match_cnt_ff, match_cnt_in;
   logic [CNT_W-1:0]   dist_cnt_ff, dist_cnt_in;
   logic [CNT_W-1:0]   match_out_ff;
   logic [CNT_W-1:0]   dist_out_ff;
   logic               s2_hit;
   logic               s2_new;
   logic               seen_we;
   logic [VAL_W-1:0]   seen_waddr;
   logic [EPOCH_W-1:0] seen_wdata;

   // mark already set this query, or set by the element just ahead
   assign s2_hit = (seen_rd_ff == epoch_ff) || (wr_en_ff && (wr_val_ff == s2_value_ff));
   assign s2_new = s2_valid_ff && s2_match_ff && !s2_hit;

   always_comb begin
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      vmin_in      = vmin_ff;
      vmax_in      = vmax_ff;
      clr_addr_in  = clr_addr_ff;
      epoch_in     = epoch_ff;
      match_cnt_in = match_cnt_ff;
      dist_cnt_in  = dist_cnt_ff;
      s1_valid_in  = cmd.walk_step;
      s2_valid_in  = s1_valid_ff;
      s2_match_in  = s1_valid_ff && (elem_rd_ff >= vmin_ff) && (elem_rd_ff <= vmax_ff);
      wr_en_in     = s2_valid_ff && s2_match_ff;
      if (cmd.query_start) begin
         idx_in       = left_index;
         hi_in        = right_index;
         vmin_in      = value_min;
         vmax_in      = value_max;
         epoch_in     = epoch_ff + EPOCH_W'(1);
         match_cnt_in = '0;
         dist_cnt_in  = '0;
      end else begin
         if (cmd.walk_step) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (s2_valid_ff && s2_match_ff) begin
            match_cnt_in = match_cnt_ff + CNT_W'(1);
         end
         if (s2_new) begin
            dist_cnt_in = dist_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + VAL_W'(1);
         epoch_in    = '0;
      end
   end

   always_comb begin
      if (cmd.clear_step) begin
         seen_we    = 1'b1;
         seen_waddr = clr_addr_ff;
         seen_wdata = '0;
      end else begin
         seen_we    = s2_valid_ff && s2_match_ff;
         seen_waddr = s2_value_ff;
         seen_wdata = epoch_ff;
      end
   end

   always_comb begin
      status.window_empty = left_index > right_index;
      status.walk_last    = idx_ff == hi_ff;
      status.pipe_busy    = s1_valid_ff || s2_valid_ff;
      status.clear_last   = clr_addr_ff == VAL_W'(VALUE_RANGE - 1);
      status.epoch_last   = epoch_ff == {EPOCH_W{1'b1}};
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         elem_mem[elem_index] <= elem_value;
      end
      elem_rd_ff <= elem_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      seen_rd_ff <= seen_mem[elem_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_en_ff    <= 1'b0;
         clr_addr_ff <= '0;
         epoch_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         wr_en_ff    <= wr_en_in;
         clr_addr_ff <= clr_addr_in;
         epoch_ff    <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      hi_ff        <= hi_in;
      vmin_ff      <= vmin_in;
      vmax_ff      <= vmax_in;
      s2_match_ff  <= s2_match_in;
      s2_value_ff  <= elem_rd_ff;
      wr_val_ff    <= s2_value_ff;
      match_cnt_ff <= match_cnt_in;
      dist_cnt_ff  <= dist_cnt_in;
      if (cmd.result_load) begin
         match_out_ff <= match_cnt_ff;
         dist_out_ff  <= dist_cnt_ff;
      end
   end

   assign match_count    = match_out_ff;
   assign distinct_count = dist_out_ff;

endmodule

@@ rtl/rvcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rvcd_ctrl
// Sequencer: mark clearing, loads, query walk, drain and result hand-off.
// ----------------------------------------------------------------------------
module rvcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  rvcd_pkg::status_type status,
   output rvcd_pkg::cmd_type    cmd
);
   import rvcd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_beat;

   assign req_beat = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_beat) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.query_start = 1'b1;
                  state_in = status.window_empty ? ST_DONE : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = status.epoch_last ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ rtl/range_value_count_distinct.sv @@
// ----------------------------------------------------------------------------
// range_value_count_distinct
// Loadable 1024-entry value array answering window count and distinct
// value count queries.
// ----------------------------------------------------------------------------
// A load beat writes one element and gives no response. A query beat walks
// its index window one element per cycle through the element RAM read port,
// then the pipeline drains and the response register is loaded once any
// earlier response has been taken. Seen marks are epoch tags; after reset and
// after every 255th query a clearing pass over all 1024 marks runs during
// which no beat is accepted. A waiting response does not block loads or the
// next query walk.
module range_value_count_distinct (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] elem_index, [19:10] elem_value, [29:20] left_index,
   // [39:30] right_index, [49:40] value_min, [59:50] value_max
   input  logic [rvcd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [10:0] match_count, [21:11] distinct_count
   output logic [rvcd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rvcd_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [CNT_W-1:0] match_count;
   logic [CNT_W-1:0] distinct_count;

   rvcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rvcd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .elem_index     (req_tdata[9:0]),
      .elem_value     (req_tdata[19:10]),
      .left_index     (req_tdata[29:20]),
      .right_index    (req_tdata[39:30]),
      .value_min      (req_tdata[49:40]),
      .value_max      (req_tdata[59:50]),
      .match_count    (match_count),
      .distinct_count (distinct_count)
   );

   assign rsp_tdata = {2'b00, distinct_count, match_count};

endmodule
